@@ hdl/pdb_pkg.sv @@
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types, constants and colour blend functions for the palette
// down-scale blend blitter.
// ----------------------------------------------------------------------------
package pdb_pkg;

  localparam int PALETTE_ENTRIES = 4096;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int MAX_DIMENSION   = 1024;
  localparam int DIM_W           = $clog2(MAX_DIMENSION) + 1;
  localparam int COORD_W         = 10;
  localparam int COLOUR_W        = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 11;

  // queue between front and back
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  // result queue
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_PIXEL     = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB444 = 2'd1,
    FMT_RGB555 = 2'd2,
    FMT_RGB888 = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_COL_SKIP_MASK = 3'd2,
    REG_ROW_SKIP_MASK = 3'd3,
    REG_PIXEL_FORMAT  = 3'd4,
    REG_BLEND_ENABLE  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_SKIP  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_BLEND = 2'd2
  } act_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [PAL_AW-1:0]   index;
    logic [COLOUR_W-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [COLOUR_W-1:0] pixel_value;
    logic                is_rewrite;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   source_width;
    logic [DIM_W-1:0]   source_height;
    logic [COORD_W-1:0] col_mask;
    logic [COORD_W-1:0] row_mask;
    fmt_t               fmt;
    logic               blend_en;
  } cfg_t;

  typedef struct packed {
    act_t                act;
    logic                row_kept;
    logic                line_end;
    logic                frame_end;
    logic [COLOUR_W-1:0] colour;
  } job_t;

  function automatic logic [15:0] blend16_mask(int r, int g, int b);
    logic [16:0] m;
    m = (17'd1 << (r + g + b)) - 17'd1;
    m[0] = 1'b0;
    m[b] = 1'b0;
    m[b + g] = 1'b0;
    return m[15:0];
  endfunction

  localparam logic [15:0] MASK_565 = blend16_mask(5, 6, 5);
  localparam logic [15:0] MASK_444 = blend16_mask(4, 4, 4);
  localparam logic [15:0] MASK_555 = blend16_mask(5, 5, 5);

  // channel LSBs cleared so the halves never carry into the next channel
  function automatic logic [COLOUR_W-1:0] blend16(logic [15:0] p, logic [15:0] n,
                                                  logic [15:0] m);
    logic [15:0] s;
    s = ((p & m) >> 1) + ((n & m) >> 1);
    if (p == n) begin
      return {8'h00, p};
    end
    return {8'h00, s};
  endfunction

  function automatic logic [COLOUR_W-1:0] blend888(logic [COLOUR_W-1:0] p,
                                                   logic [COLOUR_W-1:0] n);
    logic [COLOUR_W-1:0] r;
    for (int i = 0; i < 3; i++) begin
      r[i*8 +: 8] = {1'b0, p[i*8+1 +: 7]} + {1'b0, n[i*8+1 +: 7]};
    end
    return r;
  endfunction

  function automatic logic [COLOUR_W-1:0] blend_pixel(fmt_t f, logic [COLOUR_W-1:0] p,
                                                      logic [COLOUR_W-1:0] n);
    logic [COLOUR_W-1:0] r;
    case (f)
      FMT_RGB565: r = blend16(p[15:0], n[15:0], MASK_565);
      FMT_RGB444: r = blend16(p[15:0], n[15:0], MASK_444);
      FMT_RGB555: r = blend16(p[15:0], n[15:0], MASK_555);
      default:    r = blend888(p, n);
    endcase
    return r;
  endfunction

endpackage

@@ hdl/palette_downscale_blend_blitter.sv @@
// ----------------------------------------------------------------------------
// palette_downscale_blend_blitter
// Palette lookup, row/column down-scaling and column blending of a raster
// stream of palette indexes.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------
//   input    | push / full                 | item   (cmd, index, color)
//   result   | pop / empty                 | result (out_x, out_y,
//            |                             |         pixel_value, is_rewrite)
//   config   | cfg_write (no wait)         | cfg_index, cfg_data
//
// One item per clock sustained while full stays low. A pixel's result passes
// through the palette read stage and the job queue, and the back end writes it
// into the result queue, from which it is shown on the result ports.
// Reset is synchronous; palette contents are undefined until written.
// full rises once the job queue and the palette read stage hold four items;
// the result queue holds two beats, and the back end stalls when it is full.
// ----------------------------------------------------------------------------
module palette_downscale_blend_blitter import pdb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_item_t              item,
  output logic                  full,
  output out_item_t             result,
  output logic                  empty,
  input  logic                  pop,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic             s1_valid;
  job_t             s1_job;
  job_t             jq_head;
  logic [JQ_CW-1:0] jq_count;
  logic             job_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= DIM_W'(320);
      cfg.source_height <= DIM_W'(240);
      cfg.col_mask      <= '0;
      cfg.row_mask      <= '0;
      cfg.fmt           <= FMT_RGB565;
      cfg.blend_en      <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= cfg_data[DIM_W-1:0];
        REG_COL_SKIP_MASK: cfg.col_mask      <= cfg_data[COORD_W-1:0];
        REG_ROW_SKIP_MASK: cfg.row_mask      <= cfg_data[COORD_W-1:0];
        REG_PIXEL_FORMAT:  cfg.fmt           <= fmt_t'(cfg_data[1:0]);
        REG_BLEND_ENABLE:  cfg.blend_en      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pdb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .item     (item),
    .full     (full),
    .jq_count (jq_count),
    .s1_valid (s1_valid),
    .s1_job   (s1_job)
  );

  pdb_job_queue u_job_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_job (s1_job),
    .pop      (job_take),
    .head     (jq_head),
    .count    (jq_count)
  );

  pdb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (jq_count != '0),
    .job       (jq_head),
    .job_take  (job_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

@@ hdl/pdb_front.sv @@
// ----------------------------------------------------------------------------
// pdb_front
// Takes palette writes and source pixels. Holds the palette store and the
// source row/column counters, classifies each pixel and looks up its colour.
// ----------------------------------------------------------------------------
module pdb_front import pdb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             push,
  input  in_item_t         item,
  output logic             full,
  input  logic [JQ_CW-1:0] jq_count,
  output logic             s1_valid,
  output job_t             s1_job
);

  logic [COLOUR_W-1:0] pal_mem [PALETTE_ENTRIES];
  logic [COLOUR_W-1:0] rd_data;

  logic [COORD_W-1:0] src_col, src_row, src_col_next, src_row_next;
  logic [DIM_W-1:0]   w, h;
  logic [COORD_W-1:0] xd, yd;
  logic               accept, is_pixel, row_kept, col_drop, line_end, frame_end;
  act_t               act, s1_act;
  logic               s1_row_kept, s1_line_end, s1_frame_end;
  logic [JQ_CW-1:0]   level;

  // items in the job queue or in the palette read stage on their way into it
  assign level    = jq_count + JQ_CW'(s1_valid);
  assign full     = (level >= JQ_CW'(JQ_DEPTH));
  assign accept   = push && !full;
  assign is_pixel = (item.cmd == CMD_PIXEL);

  always_comb begin
    w = cfg.source_width;
    if (cfg.source_width == '0) begin
      w = DIM_W'(1);
    end else if (cfg.source_width > DIM_W'(MAX_DIMENSION)) begin
      w = DIM_W'(MAX_DIMENSION);
    end
    h = cfg.source_height;
    if (cfg.source_height == '0) begin
      h = DIM_W'(1);
    end else if (cfg.source_height > DIM_W'(MAX_DIMENSION)) begin
      h = DIM_W'(MAX_DIMENSION);
    end

    xd = (DIM_W'(src_col) < w) ? COORD_W'(w - DIM_W'(1) - DIM_W'(src_col)) : '0;
    yd = (DIM_W'(src_row) < h) ? COORD_W'(h - DIM_W'(1) - DIM_W'(src_row)) : '0;

    row_kept  = !((cfg.row_mask != '0) && ((yd & cfg.row_mask) == '0));
    col_drop  = (cfg.col_mask != '0) && ((xd & cfg.col_mask) == '0);
    line_end  = (xd == '0);
    frame_end = line_end && (yd == '0);

    if (!row_kept) begin
      act = ACT_SKIP;
    end else if (col_drop) begin
      act = ACT_BLEND;
    end else begin
      act = ACT_WRITE;
    end

    src_col_next = src_col;
    src_row_next = src_row;
    if (accept && is_pixel) begin
      if (line_end) begin
        src_col_next = '0;
        src_row_next = frame_end ? '0 : src_row + COORD_W'(1);
      end else begin
        src_col_next = src_col + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col  <= '0;
      src_row  <= '0;
      s1_valid <= 1'b0;
    end else begin
      src_col  <= src_col_next;
      src_row  <= src_row_next;
      s1_valid <= accept && is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_pixel) begin
      pal_mem[item.index] <= item.color;
    end
    if (accept && is_pixel) begin
      rd_data <= pal_mem[item.index];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      s1_act       <= act;
      s1_row_kept  <= row_kept;
      s1_line_end  <= line_end;
      s1_frame_end <= frame_end;
    end
  end

  always_comb begin
    s1_job.act       = s1_act;
    s1_job.row_kept  = s1_row_kept;
    s1_job.line_end  = s1_line_end;
    s1_job.frame_end = s1_frame_end;
    s1_job.colour    = rd_data;
  end

endmodule

@@ hdl/pdb_job_queue.sv @@
// ----------------------------------------------------------------------------
// pdb_job_queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module pdb_job_queue import pdb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  job_t             push_job,
  input  logic             pop,
  output job_t             head,
  output logic [JQ_CW-1:0] count
);

  job_t             q_mem [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr, rd_ptr;

  assign head = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + JQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + JQ_AW'(1);
      end
      count <= count + JQ_CW'(push) - JQ_CW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> (count < JQ_CW'(JQ_DEPTH)))
    else $error("job queue overflow");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("job queue underflow");

  a_count_track : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count + JQ_CW'(push) - JQ_CW'(pop))))
    else $error("job queue count drifted");
`endif

endmodule

@@ hdl/pdb_back.sv @@
// ----------------------------------------------------------------------------
// pdb_back
// Carries out classified pixels: destination counters, last written pixel,
// column blending, and the result queue.
// ----------------------------------------------------------------------------
module pdb_back import pdb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_take,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  logic [DIM_W-1:0]    dest_col, dest_row, dest_col_next, dest_row_next;
  logic [COLOUR_W-1:0] last_pixel, last_pixel_next, colour, blended;
  logic                last_valid, last_valid_next;
  logic                emit, pop_ok;
  out_item_t           res;

  out_item_t           out_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]    out_wr_ptr, out_rd_ptr;
  logic [OQ_CW-1:0]    out_count;

  assign job_take = job_valid && (out_count < OQ_CW'(OQ_DEPTH));
  assign empty    = (out_count == '0);
  assign pop_ok   = pop && !empty;
  assign result   = out_mem[out_rd_ptr];

  always_comb begin
    colour  = (cfg.fmt == FMT_RGB888) ? job.colour : {8'h00, job.colour[15:0]};
    blended = blend_pixel(cfg.fmt, last_pixel, colour);

    dest_col_next   = dest_col;
    dest_row_next   = dest_row;
    last_pixel_next = last_pixel;
    last_valid_next = last_valid;
    emit            = 1'b0;
    res.out_x       = COORD_W'(dest_col);
    res.out_y       = COORD_W'(dest_row);
    res.pixel_value = colour;
    res.is_rewrite  = 1'b0;

    if (job_take) begin
      case (job.act)
        ACT_WRITE: begin
          emit            = 1'b1;
          last_pixel_next = colour;
          last_valid_next = 1'b1;
          if (dest_col < DIM_W'(MAX_DIMENSION)) begin
            dest_col_next = dest_col + DIM_W'(1);
          end
        end
        ACT_BLEND: begin
          if (cfg.blend_en && last_valid) begin
            emit            = 1'b1;
            last_pixel_next = blended;
            res.out_x       = COORD_W'(dest_col - DIM_W'(1));
            res.pixel_value = blended;
            res.is_rewrite  = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (job.line_end) begin
        last_valid_next = 1'b0;
        dest_col_next   = '0;
        if (job.frame_end) begin
          dest_row_next = '0;
        end else if (job.row_kept && dest_row < DIM_W'(MAX_DIMENSION)) begin
          dest_row_next = dest_row + DIM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_col   <= '0;
      dest_row   <= '0;
      last_valid <= 1'b0;
      last_pixel <= '0;
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      dest_col   <= dest_col_next;
      dest_row   <= dest_row_next;
      last_valid <= last_valid_next;
      last_pixel <= last_pixel_next;
      if (emit) begin
        out_wr_ptr <= out_wr_ptr + OQ_AW'(1);
      end
      if (pop_ok) begin
        out_rd_ptr <= out_rd_ptr + OQ_AW'(1);
      end
      out_count <= out_count + OQ_CW'(emit) - OQ_CW'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mem[out_wr_ptr] <= res;
    end
  end

`ifndef SYNTHESIS
  a_rewrite_after_write : assert property (@(posedge clk) disable iff (rst)
    (emit && res.is_rewrite) |-> (dest_col != '0))
    else $error("rewrite with no earlier pixel on the line");

  a_result_room : assert property (@(posedge clk) disable iff (rst)
    emit |-> (out_count < OQ_CW'(OQ_DEPTH)))
    else $error("result queue overflow");
`endif

endmodule
